// ----- rtl/stq_pkg.sv -----
`timescale 1ns / 1ps

package stq_pkg;

  localparam int unsigned QueueDepthDefault = 16;

  localparam int unsigned SecW     = 32;
  localparam int unsigned UsecW    = 20;
  localparam int unsigned DlSecW   = 33;
  localparam int unsigned DlUsecW  = 21;
  localparam int unsigned WaitSecW = 33;

  localparam logic [DlUsecW-1:0] UsecMax    = DlUsecW'(999999);
  localparam logic [DlUsecW-1:0] UsecPerSec = DlUsecW'(1000000);

  // action codes
  localparam logic [1:0] ACT_ADD     = 2'd0;
  localparam logic [1:0] ACT_REMOVE  = 2'd1;
  localparam logic [1:0] ACT_UPDATE  = 2'd2;
  localparam logic [1:0] ACT_TRIGGER = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [SecW-1:0]  last_sec;
    logic [UsecW-1:0] last_usec;
    logic [SecW-1:0]  interval_sec;
    logic [UsecW-1:0] interval_usec;
  } entry_t;

  typedef struct packed {
    logic [DlSecW-1:0]  sec;
    logic [DlUsecW-1:0] usec;
  } dl_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the incoming transaction
    logic rd_en;    // read one slot
    logic wr_en;    // write one slot
    logic wr_key;   // write the key entry instead of the slot just read
    logic key_new;  // key entry is the replacement entry
    logic kd_load;  // register the key deadline
    logic hd_load;  // register the head deadline
  } stq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_geq;    // deadline of slot read >= key deadline
    logic slot_match;  // slot read equals the entry to remove
  } stq_stat_t;

  // last plus interval with a single microsecond carry
  function automatic dl_t deadline(entry_t e);
    dl_t                r;
    logic [DlUsecW-1:0] u;
    logic               c;
    u = {1'b0, e.last_usec} + {1'b0, e.interval_usec};
    c = (u > UsecMax);
    r.sec  = {1'b0, e.last_sec} + {1'b0, e.interval_sec} + {{(DlSecW-1){1'b0}}, c};
    r.usec = c ? (u - UsecPerSec) : u;
    return r;
  endfunction

  function automatic logic time_geq(dl_t a, dl_t b);
    return (a.sec > b.sec) || ((a.sec == b.sec) && (a.usec >= b.usec));
  endfunction

endpackage

// ----- rtl/stq_datapath.sv -----
`timescale 1ns / 1ps

module stq_datapath #(
  parameter int unsigned QUEUE_DEPTH = stq_pkg::QueueDepthDefault,
  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                               clk,
  input  stq_pkg::stq_cmd_t                  cmd,
  input  logic [IdxW-1:0]                    rd_addr,
  input  logic [IdxW-1:0]                    wr_addr,
  output stq_pkg::stq_stat_t                 stat,
  input  logic [stq_pkg::SecW-1:0]           last_sec,
  input  logic [stq_pkg::UsecW-1:0]          last_usec,
  input  logic [stq_pkg::SecW-1:0]           interval_sec,
  input  logic [stq_pkg::UsecW-1:0]          interval_usec,
  input  logic [stq_pkg::SecW-1:0]           new_last_sec,
  input  logic [stq_pkg::UsecW-1:0]          new_last_usec,
  input  logic [stq_pkg::SecW-1:0]           new_interval_sec,
  input  logic [stq_pkg::UsecW-1:0]          new_interval_usec,
  input  logic [stq_pkg::SecW-1:0]           now_sec,
  input  logic [stq_pkg::UsecW-1:0]          now_usec,
  output logic [stq_pkg::WaitSecW-1:0]       wait_sec,
  output logic [stq_pkg::UsecW-1:0]          wait_usec
);

  stq_pkg::entry_t                 mem [QUEUE_DEPTH];
  stq_pkg::entry_t                 rd_data;
  stq_pkg::entry_t                 old_entry;
  stq_pkg::entry_t                 repl_entry;
  stq_pkg::entry_t                 key_entry;
  stq_pkg::entry_t                 wr_data;
  logic [stq_pkg::SecW-1:0]        now_sec_r;
  logic [stq_pkg::UsecW-1:0]       now_usec_r;
  stq_pkg::dl_t                    kd;
  stq_pkg::dl_t                    hd;
  stq_pkg::dl_t                    now_dl;
  stq_pkg::dl_t                    slot_dl;
  logic                            borrow;
  logic [stq_pkg::DlUsecW:0]       wu_wide;

  // transaction capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      old_entry  <= '{last_sec, last_usec, interval_sec, interval_usec};
      repl_entry <= '{new_last_sec, new_last_usec, new_interval_sec, new_interval_usec};
      now_sec_r  <= now_sec;
      now_usec_r <= now_usec;
    end
  end

  assign key_entry = cmd.key_new ? repl_entry : old_entry;
  assign wr_data   = cmd.wr_key ? key_entry : rd_data;

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.kd_load) begin
      kd <= stq_pkg::deadline(key_entry);
    end
    if (cmd.hd_load) begin
      hd <= stq_pkg::deadline(rd_data);
    end
  end

  assign slot_dl         = stq_pkg::deadline(rd_data);
  assign stat.slot_geq   = stq_pkg::time_geq(slot_dl, kd);
  assign stat.slot_match = (rd_data == old_entry);

  // head deadline minus now, clamped at zero
  always_comb begin
    now_dl.sec  = {1'b0, now_sec_r};
    now_dl.usec = {1'b0, now_usec_r};
    borrow      = (hd.usec < now_dl.usec);
    wu_wide     = borrow ? ({1'b0, hd.usec} + {1'b0, stq_pkg::UsecPerSec} - {1'b0, now_dl.usec})
                         : ({1'b0, hd.usec} - {1'b0, now_dl.usec});
    if (stq_pkg::time_geq(hd, now_dl)) begin
      wait_sec  = hd.sec - now_dl.sec - {{(stq_pkg::WaitSecW-1){1'b0}}, borrow};
      wait_usec = wu_wide[stq_pkg::UsecW-1:0];
    end else begin
      wait_sec  = '0;
      wait_usec = '0;
    end
  end

endmodule

// ----- rtl/stq_ctrl.sv -----
`timescale 1ns / 1ps

module stq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = stq_pkg::QueueDepthDefault,
  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic               out_free,
  output logic               done,
  output logic [1:0]         res_status,
  output logic               res_has,
  output stq_pkg::stq_cmd_t  cmd,
  output logic [IdxW-1:0]    rd_addr,
  output logic [IdxW-1:0]    wr_addr,
  input  stq_pkg::stq_stat_t stat
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADD_INIT = 4'd1;
  localparam logic [3:0] S_ADD_SCAN = 4'd2;
  localparam logic [3:0] S_ADD_PUT  = 4'd3;
  localparam logic [3:0] S_RM_INIT  = 4'd4;
  localparam logic [3:0] S_RM_SCAN  = 4'd5;
  localparam logic [3:0] S_TRIG_RD  = 4'd6;
  localparam logic [3:0] S_TRIG_DL  = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;

  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  logic [3:0]      state, state_next;
  logic [CntW-1:0] count, count_next;
  logic [IdxW-1:0] idx, idx_next;
  logic            found, found_next;
  logic            upd, upd_next;
  logic [1:0]      status_r, status_next;
  logic            has_r, has_next;
  logic [CntW-1:0] cnt_m1;
  logic            at_last;

  assign cnt_m1     = count - 1'b1;
  assign at_last    = (CntW'(idx) == cnt_m1);
  assign in_stall   = (state != S_IDLE);
  assign res_status = status_r;
  assign res_has    = has_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      idx      <= '0;
      found    <= 1'b0;
      upd      <= 1'b0;
      status_r <= stq_pkg::ST_OK;
      has_r    <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      idx      <= idx_next;
      found    <= found_next;
      upd      <= upd_next;
      status_r <= status_next;
      has_r    <= has_next;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    found_next  = found;
    upd_next    = upd;
    status_next = status_r;
    has_next    = has_r;
    cmd         = '0;
    cmd.key_new = upd;
    rd_addr     = '0;
    wr_addr     = '0;
    done        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          has_next    = 1'b0;
          status_next = stq_pkg::ST_OK;
          upd_next    = (action == stq_pkg::ACT_UPDATE);
          unique case (action)
            stq_pkg::ACT_ADD: begin
              if (count == CntFull) begin
                status_next = stq_pkg::ST_FULL;
                state_next  = S_FIN;
              end else begin
                state_next = S_ADD_INIT;
              end
            end
            stq_pkg::ACT_REMOVE, stq_pkg::ACT_UPDATE: begin
              if (count == '0) begin
                status_next = stq_pkg::ST_NOT_FOUND;
                state_next  = S_FIN;
              end else begin
                state_next = S_RM_INIT;
              end
            end
            stq_pkg::ACT_TRIGGER: begin
              state_next = (count == '0) ? S_FIN : S_TRIG_RD;
            end
          endcase
        end
      end

      // scan from the tail, moving later or equal deadlines up one slot
      S_ADD_INIT: begin
        cmd.kd_load = 1'b1;
        if (count == '0) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_key  = 1'b1;
          count_next  = count + 1'b1;
          status_next = stq_pkg::ST_OK;
          state_next  = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          rd_addr    = cnt_m1[IdxW-1:0];
          idx_next   = cnt_m1[IdxW-1:0];
          state_next = S_ADD_SCAN;
        end
      end

      S_ADD_SCAN: begin
        cmd.wr_en = 1'b1;
        wr_addr   = idx + 1'b1;
        if (stat.slot_geq) begin
          if (idx == '0) begin
            state_next = S_ADD_PUT;
          end else begin
            cmd.rd_en = 1'b1;
            rd_addr   = idx - 1'b1;
            idx_next  = idx - 1'b1;
          end
        end else begin
          cmd.wr_key  = 1'b1;
          count_next  = count + 1'b1;
          status_next = stq_pkg::ST_OK;
          state_next  = S_FIN;
        end
      end

      S_ADD_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_key  = 1'b1;
        count_next  = count + 1'b1;
        status_next = stq_pkg::ST_OK;
        state_next  = S_FIN;
      end

      // forward scan; once matched, each later slot moves down one
      S_RM_INIT: begin
        cmd.rd_en  = 1'b1;
        idx_next   = '0;
        found_next = 1'b0;
        state_next = S_RM_SCAN;
      end

      S_RM_SCAN: begin
        if (found) begin
          cmd.wr_en = 1'b1;
          wr_addr   = idx - 1'b1;
        end
        if (at_last) begin
          if (found || stat.slot_match) begin
            count_next = count - 1'b1;
            if (upd) begin
              state_next = S_ADD_INIT;
            end else begin
              status_next = stq_pkg::ST_OK;
              state_next  = S_FIN;
            end
          end else begin
            status_next = stq_pkg::ST_NOT_FOUND;
            state_next  = S_FIN;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          rd_addr    = idx + 1'b1;
          idx_next   = idx + 1'b1;
          found_next = found || stat.slot_match;
        end
      end

      S_TRIG_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_TRIG_DL;
      end

      S_TRIG_DL: begin
        cmd.hd_load = 1'b1;
        has_next    = 1'b1;
        status_next = stq_pkg::ST_OK;
        state_next  = S_FIN;
      end

      S_FIN: begin
        if (out_free) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntFull)
    else $error("used count above depth");

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> out_free)
    else $error("result issued while output register busy");

  a_port_clash: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en && cmd.wr_en) |-> (rd_addr != wr_addr))
    else $error("slot read and write at the same address");

  a_full_keeps: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && action == stq_pkg::ACT_ADD && count == CntFull)
      |=> (count == $past(count)) && (status_r == stq_pkg::ST_FULL))
    else $error("add on a full queue changed the queue");

  a_has_trigger: assert property (@(posedge clk) disable iff (rst)
    (done && has_r) |-> (count != '0))
    else $error("trigger result on an empty queue");

endmodule

// ----- rtl/sorted_timer_queue.sv -----
`timescale 1ns / 1ps

// channel  direction  handshake            payload
// in       input      in_valid / in_stall   action, last_*, interval_*, new_*, now_*
// out      output     out_valid / out_stall status, has_entry, wait_sec, wait_usec
//
// one transaction at a time; remove scans every used slot, add scans from the
// tail down to its place, update does a remove and then an add, trigger reads the head
// the slot memory has one read and one write port, so the scan and the shift
// move one slot per cycle
// rst is synchronous and empties the queue; slot contents are not cleared
// in_stall is high from acceptance until the result enters the output
// register; a new transaction is accepted while an earlier result waits

module sorted_timer_queue #(
  parameter int unsigned QUEUE_DEPTH = stq_pkg::QueueDepthDefault,
  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  // input transaction channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     action,
  input  logic [stq_pkg::SecW-1:0]       last_sec,
  input  logic [stq_pkg::UsecW-1:0]      last_usec,
  input  logic [stq_pkg::SecW-1:0]       interval_sec,
  input  logic [stq_pkg::UsecW-1:0]      interval_usec,
  input  logic [stq_pkg::SecW-1:0]       new_last_sec,
  input  logic [stq_pkg::UsecW-1:0]      new_last_usec,
  input  logic [stq_pkg::SecW-1:0]       new_interval_sec,
  input  logic [stq_pkg::UsecW-1:0]      new_interval_usec,
  input  logic [stq_pkg::SecW-1:0]       now_sec,
  input  logic [stq_pkg::UsecW-1:0]      now_usec,
  // result transaction channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic                           has_entry,
  output logic [stq_pkg::WaitSecW-1:0]   wait_sec,
  output logic [stq_pkg::UsecW-1:0]      wait_usec
);

  stq_pkg::stq_cmd_t               cmd;
  stq_pkg::stq_stat_t              stat;
  logic [IdxW-1:0]                 rd_addr;
  logic [IdxW-1:0]                 wr_addr;
  logic                            done;
  logic                            out_free;
  logic [1:0]                      res_status;
  logic                            res_has;
  logic [stq_pkg::WaitSecW-1:0]    dp_wait_sec;
  logic [stq_pkg::UsecW-1:0]       dp_wait_usec;

  // output register is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  stq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .out_free   (out_free),
    .done       (done),
    .res_status (res_status),
    .res_has    (res_has),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .stat       (stat)
  );

  stq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .cmd               (cmd),
    .rd_addr           (rd_addr),
    .wr_addr           (wr_addr),
    .stat              (stat),
    .last_sec          (last_sec),
    .last_usec         (last_usec),
    .interval_sec      (interval_sec),
    .interval_usec     (interval_usec),
    .new_last_sec      (new_last_sec),
    .new_last_usec     (new_last_usec),
    .new_interval_sec  (new_interval_sec),
    .new_interval_usec (new_interval_usec),
    .now_sec           (now_sec),
    .now_usec          (now_usec),
    .wait_sec          (dp_wait_sec),
    .wait_usec         (dp_wait_usec)
  );

  // output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register: payload, wait fields only on a trigger with entries
  always_ff @(posedge clk) begin
    if (done) begin
      status    <= res_status;
      has_entry <= res_has;
      wait_sec  <= res_has ? dp_wait_sec : '0;
      wait_usec <= res_has ? dp_wait_usec : '0;
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import stq_pkg::*;

  localparam int Depth        = QueueDepthDefault;
  localparam int RandPerPhase = 388;

  // one input transaction as the driver sees it
  typedef struct packed {
    logic [1:0] act;
    entry_t     old;     // entry to add, remove or replace
    entry_t     nw;      // replacement entry for update
    logic [31:0] now_s;
    logic [19:0] now_u;
  } txn_t;

  // one result transaction
  typedef struct packed {
    logic [1:0]  status;
    logic        has;
    logic [32:0] ws;
    logic [19:0] wu;
  } reply_t;

  // directed table row; rep > 1 repeats the row with the entry stepped by one
  typedef struct packed {
    txn_t       t;
    logic [4:0] rep;
    logic       typed;   // want holds a hand-written answer
    reply_t     want;
  } row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          action = ACT_TRIGGER;
  logic [SecW-1:0]     last_sec = '0;
  logic [UsecW-1:0]    last_usec = '0;
  logic [SecW-1:0]     interval_sec = '0;
  logic [UsecW-1:0]    interval_usec = '0;
  logic [SecW-1:0]     new_last_sec = '0;
  logic [UsecW-1:0]    new_last_usec = '0;
  logic [SecW-1:0]     new_interval_sec = '0;
  logic [UsecW-1:0]    new_interval_usec = '0;
  logic [SecW-1:0]     now_sec = '0;
  logic [UsecW-1:0]    now_usec = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          status;
  logic                has_entry;
  logic [WaitSecW-1:0] wait_sec;
  logic [UsecW-1:0]    wait_usec;

  sorted_timer_queue uut (.*);

  // shadow copy of the timer list, kept sorted by deadline
  entry_t book [Depth];
  int     fill = 0;

  reply_t replies_owed [$];
  row_t   plan_rows [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int act_count [4] = '{0, 0, 0, 0};
  int full_hits = 0;
  int missing_hits = 0;
  int passed_hits = 0;
  int empty_hits = 0;
  int peak_fill = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // deadline packed as {seconds[32:0], microseconds[20:0]} so that a plain
  // unsigned compare orders by seconds first, then microseconds
  function automatic logic [53:0] deadline_of(entry_t e);
    logic [63:0] s;
    logic [63:0] u;
    s = 64'(e.last_sec) + 64'(e.interval_sec);
    u = 64'(e.last_usec) + 64'(e.interval_usec);
    if (u > 64'(UsecMax)) begin
      s = s + 64'd1;
      u = u - 64'(UsecPerSec);
    end
    return {s[32:0], u[20:0]};
  endfunction

  function automatic logic [1:0] book_insert(entry_t e);
    logic [53:0] key;
    int          pos;
    if (fill >= Depth) return ST_FULL;
    key = deadline_of(e);
    pos = fill;
    // backward scan leaves pos on the first slot with deadline >= key
    for (int k = fill - 1; k >= 0; k--)
      if (deadline_of(book[k]) >= key) pos = k;
    for (int k = fill; k > pos; k--) book[k] = book[k - 1];
    book[pos] = e;
    fill++;
    if (fill > peak_fill) peak_fill = fill;
    return ST_OK;
  endfunction

  function automatic logic [1:0] book_delete(entry_t e);
    int hit;
    hit = -1;
    for (int k = fill - 1; k >= 0; k--)
      if (book[k] == e) hit = k;
    if (hit < 0) return ST_NOT_FOUND;
    for (int k = hit; k < fill - 1; k++) book[k] = book[k + 1];
    fill--;
    return ST_OK;
  endfunction

  // applies one transaction to the shadow list and returns its result
  function automatic reply_t book_apply(txn_t t);
    reply_t      r;
    logic [53:0] d;
    logic [53:0] now;
    logic [63:0] wu;
    r = '0;
    case (t.act)
      ACT_ADD: r.status = book_insert(t.old);
      ACT_REMOVE: r.status = book_delete(t.old);
      ACT_UPDATE: begin
        r.status = book_delete(t.old);
        if (r.status == ST_OK) r.status = book_insert(t.nw);
      end
      default: begin
        if (fill > 0) begin
          d   = deadline_of(book[0]);
          now = {1'b0, t.now_s, 1'b0, t.now_u};
          r.has = 1'b1;
          if (d >= now) begin
            r.ws = d[53:21] - now[53:21];
            if (d[20:0] >= now[20:0]) begin
              wu = 64'(d[20:0]) - 64'(now[20:0]);
            end else begin
              r.ws = r.ws - 33'd1;
              wu = 64'(UsecPerSec) + 64'(d[20:0]) - 64'(now[20:0]);
            end
            r.wu = wu[19:0];
          end else begin
            passed_hits++;
          end
        end else begin
          empty_hits++;
        end
      end
    endcase
    return r;
  endfunction

  // random times lean on small values so deadlines collide and stay ahead of now
  function automatic logic [31:0] pick_sec();
    case ($urandom_range(11))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      default: return 32'($urandom_range(24));
    endcase
  endfunction

  function automatic logic [19:0] pick_usec();
    case ($urandom_range(11))
      0: return '0;
      1: return 20'd999999;
      2: return '1;
      3: return 20'($urandom);
      4: return 20'd500000;
      default: return 20'($urandom_range(999999));
    endcase
  endfunction

  function automatic entry_t random_entry();
    entry_t e;
    e.last_sec      = pick_sec();
    e.last_usec     = pick_usec();
    e.interval_sec  = pick_sec();
    e.interval_usec = pick_usec();
    return e;
  endfunction

  // an entry already in the list, now and then off by one bit
  function automatic entry_t known_entry();
    entry_t e;
    e = book[$urandom_range(fill - 1)];
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(3))
        0: e.last_sec[$urandom_range(31)] ^= 1'b1;
        1: e.last_usec[$urandom_range(19)] ^= 1'b1;
        2: e.interval_sec[$urandom_range(31)] ^= 1'b1;
        default: e.interval_usec[$urandom_range(19)] ^= 1'b1;
      endcase
    end
    return e;
  endfunction

  function automatic txn_t random_txn(logic grow);
    txn_t        t;
    int          pick;
    logic [53:0] d;
    t.old   = random_entry();
    t.nw    = random_entry();
    t.now_s = $urandom;
    t.now_u = 20'($urandom);
    pick = $urandom_range(99);
    if (grow)
      t.act = (pick < 45) ? ACT_ADD : (pick < 65) ? ACT_REMOVE :
              (pick < 80) ? ACT_UPDATE : ACT_TRIGGER;
    else
      t.act = (pick < 10) ? ACT_ADD : (pick < 70) ? ACT_REMOVE :
              (pick < 85) ? ACT_UPDATE : ACT_TRIGGER;
    if ((t.act == ACT_REMOVE || t.act == ACT_UPDATE) && fill > 0 &&
        $urandom_range(99) < 80)
      t.old = known_entry();
    if (t.act == ACT_UPDATE && $urandom_range(9) == 0) t.nw = t.old;
    if (t.act == ACT_TRIGGER) begin
      pick = $urandom_range(9);
      if (fill > 0 && pick < 5) begin
        // now lands just around the head deadline
        d = deadline_of(book[0]);
        t.now_s = d[52:21] + 32'($urandom_range(2)) - 32'd1;
        t.now_u = $urandom_range(1) ? d[19:0] : 20'($urandom_range(999999));
      end else if (pick < 8) begin
        t.now_s = pick_sec();
        t.now_u = pick_usec();
      end
    end
    return t;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch %0d at %0t: %s got %0h want %0h", mismatches, $realtime,
               what, got, want);
  endtask

  // drives one transaction, waits for it to be taken, then books the answer
  task automatic push_txn(txn_t t, logic typed, reply_t want);
    reply_t model_r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    action            <= t.act;
    last_sec          <= t.old.last_sec;
    last_usec         <= t.old.last_usec;
    interval_sec      <= t.old.interval_sec;
    interval_usec     <= t.old.interval_usec;
    new_last_sec      <= t.nw.last_sec;
    new_last_usec     <= t.nw.last_usec;
    new_interval_sec  <= t.nw.interval_sec;
    new_interval_usec <= t.nw.interval_usec;
    now_sec           <= t.now_s;
    now_usec          <= t.now_u;
    do @(posedge clk); while (in_stall !== 1'b0);
    model_r = book_apply(t);
    act_count[t.act]++;
    if (model_r.status == ST_FULL) full_hits++;
    if (model_r.status == ST_NOT_FOUND) missing_hits++;
    replies_owed.push_back(typed ? want : model_r);
  endtask

  function automatic entry_t ent(logic [31:0] ls, logic [19:0] lu, logic [31:0] isec,
                                 logic [19:0] iu);
    entry_t e;
    e.last_sec      = ls;
    e.last_usec     = lu;
    e.interval_sec  = isec;
    e.interval_usec = iu;
    return e;
  endfunction

  function automatic reply_t rsp(logic [1:0] st, logic has, logic [32:0] ws,
                                 logic [19:0] wu);
    reply_t r;
    r.status = st;
    r.has    = has;
    r.ws     = ws;
    r.wu     = wu;
    return r;
  endfunction

  function automatic void plan(logic [1:0] act, entry_t old, entry_t nw, logic [31:0] ns,
                               logic [19:0] nu, int rep, logic typed, reply_t want);
    row_t r;
    r.t.act   = act;
    r.t.old   = old;
    r.t.nw    = nw;
    r.t.now_s = ns;
    r.t.now_u = nu;
    r.rep     = 5'(rep);
    r.typed   = typed;
    r.want    = want;
    plan_rows.push_back(r);
  endfunction

  // receiver: stalls at random per phase
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result checker: each accepted result against the oldest one owed
  always @(posedge clk) begin : result_check
    reply_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (replies_owed.size() == 0) begin
        report_mismatch("result with nothing owed, status", 64'(status), 64'(0));
      end else begin
        want = replies_owed.pop_front();
        if (status !== want.status) report_mismatch("status", 64'(status), 64'(want.status));
        if (has_entry !== want.has) report_mismatch("has_entry", 64'(has_entry), 64'(want.has));
        if (wait_sec !== want.ws) report_mismatch("wait_sec", 64'(wait_sec), 64'(want.ws));
        if (wait_usec !== want.wu) report_mismatch("wait_usec", 64'(wait_usec), 64'(want.wu));
      end
    end
  end

  initial begin : stimulus
    txn_t t;
    logic grow;
    grow = 1'b1;

    // empty queue: trigger, remove and update all come back empty-handed
    plan(ACT_TRIGGER, '0, '0, '0, '0, 1, 1'b1, rsp(ST_OK, 1'b0, '0, '0));
    plan(ACT_REMOVE,  '0, '0, '0, '0, 1, 1'b1, rsp(ST_NOT_FOUND, 1'b0, '0, '0));
    plan(ACT_UPDATE,  '1, '0, '1, '1, 1, 1'b1, rsp(ST_NOT_FOUND, 1'b0, '0, '0));
    // all-ones entry, microseconds out of range, then an all-zero entry ahead of it
    plan(ACT_ADD,     '1, '0, '0, '0, 1, 1'b1, rsp(ST_OK, 1'b0, '0, '0));
    plan(ACT_ADD,     '0, '1, '1, '1, 1, 1'b1, rsp(ST_OK, 1'b0, '0, '0));
    // deadline equal to now, then long passed
    plan(ACT_TRIGGER, '1, '1, '0, '0, 1, 1'b1, rsp(ST_OK, 1'b1, '0, '0));
    plan(ACT_TRIGGER, '0, '0, '1, '1, 1, 1'b1, rsp(ST_OK, 1'b1, '0, '0));
    plan(ACT_REMOVE,  '0, '1, '0, '0, 1, 1'b1, rsp(ST_OK, 1'b0, '0, '0));
    // widest wait, and a borrow with now_usec beyond range
    plan(ACT_TRIGGER, '0, '0, '0, '0, 1, 1'b0, '0);
    plan(ACT_TRIGGER, '0, '0, '0, '1, 1, 1'b0, '0);
    plan(ACT_UPDATE,  '1, ent(10, 999999, 0, 1), '0, '0, 1, 1'b0, '0);
    // two entries with the same deadline: the later add goes in front
    plan(ACT_ADD,     ent(5, 0, 5, 0), '0, '0, '0, 1, 1'b0, '0);
    plan(ACT_ADD,     ent(3, 0, 7, 0), '0, '0, '0, 1, 1'b0, '0);
    plan(ACT_TRIGGER, '0, '0, 9, 500000, 1, 1'b0, '0);
    plan(ACT_REMOVE,  ent(5, 0, 5, 0), '0, '0, '0, 1, 1'b0, '0);
    plan(ACT_UPDATE,  ent(5, 0, 5, 0), '1, '0, '0, 1, 1'b1, rsp(ST_NOT_FOUND, 1'b0, '0, '0));
    // fill up, then one add too many
    plan(ACT_ADD,     ent(1000, 0, 5, 999999), '0, '0, '0, Depth - 2, 1'b0, '0);
    plan(ACT_ADD,     ent(1, 1, 1, 1), '0, '0, '0, 1, 1'b1, rsp(ST_FULL, 1'b0, '0, '0));
    // update on a full queue still lands, a near miss does not
    plan(ACT_UPDATE,  ent(3, 0, 7, 0), ent(2, 999999, 0, 1), '0, '0, 1, 1'b0, '0);
    plan(ACT_REMOVE,  ent(2, 999999, 0, 2), '0, '0, '0, 1, 1'b1,
         rsp(ST_NOT_FOUND, 1'b0, '0, '0));
    plan(ACT_TRIGGER, '0, '0, 2, 0, 1, 1'b0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < plan_rows.size(); i++) begin
      for (int k = 0; k < plan_rows[i].rep; k++) begin
        t = plan_rows[i].t;
        t.old.last_sec  = t.old.last_sec + 32'(k);
        t.old.last_usec = t.old.last_usec + 20'(k);
        push_txn(t, plan_rows[i].typed, plan_rows[i].want);
      end
    end

    // random part in four idling phases; each starts from a drained pipeline
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      in_valid <= 1'b0;
      do @(posedge clk); while (replies_owed.size() != 0);
      for (int n = 0; n < RandPerPhase; n++) begin
        // alternate filling and draining stretches so both ends get visited
        if (n % 48 == 0) grow = ~grow;
        push_txn(random_txn(grow), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    stall_pct = 0;
    do @(posedge clk); while (replies_owed.size() != 0);
    repeat (60) @(posedge clk);

    $display("ran %0d add, %0d remove, %0d update, %0d trigger transactions",
             act_count[ACT_ADD], act_count[ACT_REMOVE], act_count[ACT_UPDATE],
             act_count[ACT_TRIGGER]);
    $display("full %0d, not found %0d, empty triggers %0d, passed deadlines %0d, peak %0d",
             full_hits, missing_hits, empty_hits, passed_hits, peak_fill);
    if (mismatches == 0)
      $display("sorted_timer_queue test passed");
    else
      $display("sorted_timer_queue test failed");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("sorted_timer_queue test failed");
    $finish;
  end

endmodule
